// File: rtl/lprf_pkg.sv
package lprf_pkg;

    // request codes as they arrive on req_type
    localparam logic [2:0] REQ_PUSH_BEGIN = 3'd0;
    localparam logic [2:0] REQ_PUSH_BYTE  = 3'd1;
    localparam logic [2:0] REQ_POP        = 3'd2;
    localparam logic [2:0] REQ_PEEK       = 3'd3;
    localparam logic [2:0] REQ_CLEAR      = 3'd4;
    localparam logic [2:0] REQ_CHECK      = 3'd5;

    // result status codes
    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_NOSPACE = 2'd1;
    localparam logic [1:0] STATUS_EMPTY   = 2'd2;
    localparam logic [1:0] STATUS_DATA    = 2'd3;

    typedef enum logic [2:0] {
        OP_PUSH_BEGIN,
        OP_PUSH_BYTE,
        OP_POP,
        OP_PEEK,
        OP_CLEAR,
        OP_CHECK,
        OP_NOP
    } op_t;

    typedef enum logic [1:0] {
        BE_IDLE,
        BE_STREAM,
        BE_HDR
    } be_state_t;

    typedef struct packed {
        op_t        op;
        logic [6:0] len;
        logic [7:0] data;
        logic       len_ok;
    } cmd_t;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] out_byte;
        logic       last;
        logic [6:0] stored_len;
        logic       is_empty;
        logic [8:0] free_bytes;
        logic       fits;
    } res_t;

endpackage

// File: rtl/lprf_front.sv
module lprf_front #(
    parameter int MAX_RECORD = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [2:0]        req_type,
    input  logic [6:0]        length,
    input  logic [7:0]        data_byte,
    output logic              cmd_valid,
    input  logic              cmd_pop,
    output lprf_pkg::cmd_t    cmd
);

    lprf_pkg::cmd_t cmd_in;
    lprf_pkg::cmd_t q_reg [2];
    logic           wr_ptr_reg;
    logic           wr_ptr_next;
    logic           rd_ptr_reg;
    logic           rd_ptr_next;
    logic [1:0]     count_reg;
    logic [1:0]     count_next;
    logic           push;

    // classify the request
    always_comb
    begin
        cmd_in.len    = length;
        cmd_in.data   = data_byte;
        cmd_in.len_ok = (length <= 7'(MAX_RECORD));
        case (req_type)
            lprf_pkg::REQ_PUSH_BEGIN: cmd_in.op = lprf_pkg::OP_PUSH_BEGIN;
            lprf_pkg::REQ_PUSH_BYTE:  cmd_in.op = lprf_pkg::OP_PUSH_BYTE;
            lprf_pkg::REQ_POP:        cmd_in.op = lprf_pkg::OP_POP;
            lprf_pkg::REQ_PEEK:       cmd_in.op = lprf_pkg::OP_PEEK;
            lprf_pkg::REQ_CLEAR:      cmd_in.op = lprf_pkg::OP_CLEAR;
            lprf_pkg::REQ_CHECK:      cmd_in.op = lprf_pkg::OP_CHECK;
            default:                  cmd_in.op = lprf_pkg::OP_NOP;
        endcase
    end

    // two-entry command queue
    assign in_ready  = (count_reg != 2'd2);
    assign push      = in_valid && in_ready;
    assign cmd_valid = (count_reg != 2'd0);
    assign cmd       = q_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = cmd_pop ? ~rd_ptr_reg : rd_ptr_reg;
        case ({push, cmd_pop})
            2'b10:   count_next = count_reg + 2'd1;
            2'b01:   count_next = count_reg - 2'd1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= cmd_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// File: rtl/lprf_back.sv
module lprf_back #(
    parameter int RING_BYTES = 256,
    parameter int MAX_RECORD = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    input  lprf_pkg::cmd_t    cmd,
    output logic              cmd_pop,
    output logic              res_valid,
    input  logic              res_ready,
    output lprf_pkg::res_t    res
);

    localparam int AW = $clog2(RING_BYTES);
    localparam int FW = $clog2(RING_BYTES + 1);
    localparam int SW = ((FW > 8) ? FW : 8) + 1;
    localparam logic [SW-1:0] RING_S    = SW'(RING_BYTES);
    localparam logic [FW-1:0] RING_F    = FW'(RING_BYTES);
    localparam logic [AW-1:0] LAST_ADDR = AW'(RING_BYTES - 1);

    lprf_pkg::be_state_t state_reg;
    lprf_pkg::be_state_t state_next;

    logic [AW-1:0] head_reg;
    logic [AW-1:0] head_next;
    logic [AW-1:0] tail_reg;
    logic [AW-1:0] tail_next;
    logic [AW-1:0] ptr_reg;
    logic [AW-1:0] ptr_next;
    logic [FW-1:0] free_reg;
    logic [FW-1:0] free_next;
    logic [6:0]    push_rem_reg;
    logic [6:0]    push_rem_next;
    logic [6:0]    front_reg;
    logic [6:0]    front_next;
    logic [6:0]    stored_reg;
    logic [6:0]    stored_next;
    logic [6:0]    cnt_reg;
    logic [6:0]    cnt_next;
    logic          pop_mode_reg;
    logic          pop_mode_next;
    logic          res_valid_reg;
    lprf_pkg::res_t res_reg;
    lprf_pkg::res_t res_next;
    logic          res_load;

    logic [7:0]    ring_mem [RING_BYTES];
    logic [7:0]    rd_data_reg;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [7:0]    wr_data;

    logic          slot_free;
    logic          empty;
    logic          empty_next;
    logic [SW-1:0] free_s;
    logic [SW-1:0] need_s;
    logic          ok;
    logic [6:0]    n;
    logic [SW-1:0] used_s;
    logic [SW-1:0] freed_s;
    logic [SW-1:0] sum_s;
    logic [SW-1:0] tail_s;
    logic [SW-1:0] rem_s;
    logic [SW-1:0] addr_s;
    logic [AW-1:0] head_inc;
    logic [AW-1:0] ptr_inc;
    logic [FW+8:0] free_ext;

    assign slot_free = !res_valid_reg || res_ready;
    assign empty     = (free_reg == RING_F);
    assign free_s    = SW'(free_reg);
    assign need_s    = SW'(cmd.len) + SW'(1);
    assign ok        = cmd.len_ok && (need_s <= free_s);
    assign used_s    = RING_S - free_s;
    assign head_inc  = (head_reg == LAST_ADDR) ? '0 : head_reg + AW'(1);
    assign ptr_inc   = (ptr_reg == LAST_ADDR) ? '0 : ptr_reg + AW'(1);
    assign tail_s    = SW'(tail_reg);
    assign rem_s     = SW'(push_rem_reg);

    // bytes to deliver for pop and peek
    always_comb
    begin
        n = (cmd.len < front_reg) ? cmd.len : front_reg;
        if (n > 7'(MAX_RECORD))
        begin
            n = 7'(MAX_RECORD);
        end
    end

    // bytes freed by a pop, capped to what is in use
    assign freed_s = ((SW'(front_reg) + SW'(1)) > used_s) ? used_s
                                                          : SW'(front_reg) + SW'(1);

    // push_byte address: tail minus outstanding bytes, modulo ring size
    assign addr_s = (tail_s >= rem_s) ? tail_s - rem_s : tail_s + RING_S - rem_s;

    always_comb
    begin
        state_next    = state_reg;
        head_next     = head_reg;
        tail_next     = tail_reg;
        ptr_next      = ptr_reg;
        free_next     = free_reg;
        push_rem_next = push_rem_reg;
        front_next    = front_reg;
        stored_next   = stored_reg;
        cnt_next      = cnt_reg;
        pop_mode_next = pop_mode_reg;
        cmd_pop       = 1'b0;
        res_load      = 1'b0;
        wr_en         = 1'b0;
        wr_addr       = tail_reg;
        wr_data       = {1'b0, cmd.len};
        sum_s         = '0;
        res_next      = res_reg;
        res_next.status   = lprf_pkg::STATUS_OK;
        res_next.out_byte = 8'd0;
        res_next.last     = 1'b1;
        res_next.fits     = 1'b0;
        res_next.stored_len = 7'd0;

        case (state_reg)
            lprf_pkg::BE_IDLE:
            begin
                if (cmd_valid && slot_free)
                begin
                    cmd_pop  = 1'b1;
                    res_load = 1'b1;
                    case (cmd.op)
                        lprf_pkg::OP_PUSH_BEGIN:
                        begin
                            if (ok)
                            begin
                                wr_en         = 1'b1;
                                sum_s         = tail_s + need_s;
                                if (sum_s >= RING_S)
                                begin
                                    sum_s = sum_s - RING_S;
                                end
                                tail_next     = sum_s[AW-1:0];
                                free_next     = free_reg - need_s[FW-1:0];
                                push_rem_next = cmd.len;
                                if (empty)
                                begin
                                    front_next = cmd.len;
                                end
                            end
                            else
                            begin
                                push_rem_next   = 7'd0;
                                res_next.status = lprf_pkg::STATUS_NOSPACE;
                            end
                        end
                        lprf_pkg::OP_PUSH_BYTE:
                        begin
                            if (push_rem_reg != 7'd0)
                            begin
                                wr_en         = 1'b1;
                                wr_addr       = addr_s[AW-1:0];
                                wr_data       = cmd.data;
                                push_rem_next = push_rem_reg - 7'd1;
                                if (addr_s[AW-1:0] == head_reg)
                                begin
                                    front_next = cmd.data[6:0];
                                end
                            end
                        end
                        lprf_pkg::OP_POP,
                        lprf_pkg::OP_PEEK:
                        begin
                            if (empty)
                            begin
                                res_next.status = lprf_pkg::STATUS_EMPTY;
                            end
                            else
                            begin
                                pop_mode_next = (cmd.op == lprf_pkg::OP_POP);
                                stored_next   = front_reg;
                                cnt_next      = n;
                                if (cmd.op == lprf_pkg::OP_POP)
                                begin
                                    sum_s = SW'(head_reg) + freed_s;
                                    if (sum_s >= RING_S)
                                    begin
                                        sum_s = sum_s - RING_S;
                                    end
                                    head_next = sum_s[AW-1:0];
                                    free_next = free_reg + freed_s[FW-1:0];
                                    if (free_next == RING_F)
                                    begin
                                        push_rem_next = 7'd0;
                                    end
                                end
                                if (n == 7'd0)
                                begin
                                    // nothing to deliver, reload header if a record is left
                                    if ((cmd.op == lprf_pkg::OP_POP) && (free_next != RING_F))
                                    begin
                                        state_next = lprf_pkg::BE_HDR;
                                        ptr_next   = head_next;
                                    end
                                end
                                else
                                begin
                                    res_load   = 1'b0;
                                    state_next = lprf_pkg::BE_STREAM;
                                    ptr_next   = head_inc;
                                end
                            end
                        end
                        lprf_pkg::OP_CLEAR:
                        begin
                            head_next     = '0;
                            tail_next     = '0;
                            free_next     = RING_F;
                            push_rem_next = 7'd0;
                        end
                        lprf_pkg::OP_CHECK:
                        begin
                            res_next.fits = ok;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            lprf_pkg::BE_STREAM:
            begin
                if (slot_free)
                begin
                    res_load          = 1'b1;
                    res_next.status   = lprf_pkg::STATUS_DATA;
                    res_next.out_byte = rd_data_reg;
                    res_next.last     = (cnt_reg == 7'd1);
                    cnt_next          = cnt_reg - 7'd1;
                    ptr_next          = ptr_inc;
                    if (cnt_reg == 7'd1)
                    begin
                        if (pop_mode_reg && !empty)
                        begin
                            state_next = lprf_pkg::BE_HDR;
                            ptr_next   = head_reg;
                        end
                        else
                        begin
                            state_next = lprf_pkg::BE_IDLE;
                        end
                    end
                end
            end
            lprf_pkg::BE_HDR:
            begin
                front_next = rd_data_reg[6:0];
                state_next = lprf_pkg::BE_IDLE;
            end
            default:
            begin
                state_next = lprf_pkg::BE_IDLE;
            end
        endcase

        // fields that report the state after the step
        empty_next          = (free_next == RING_F);
        free_ext            = {9'd0, free_next};
        res_next.is_empty   = empty_next;
        res_next.free_bytes = free_ext[8:0];
        if ((state_reg == lprf_pkg::BE_STREAM) ||
            (cmd.op == lprf_pkg::OP_POP) || (cmd.op == lprf_pkg::OP_PEEK))
        begin
            res_next.stored_len = empty ? 7'd0 : front_reg;
            if (state_reg == lprf_pkg::BE_STREAM)
            begin
                res_next.stored_len = stored_reg;
            end
        end
        else
        begin
            res_next.stored_len = empty_next ? 7'd0 : front_next;
        end
    end

    // ring memory, read data registered
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            ring_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= ring_mem[ptr_next];
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            res_reg <= res_next;
        end
        stored_reg <= stored_next;
        cnt_reg    <= cnt_next;
        ptr_reg    <= ptr_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lprf_pkg::BE_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            free_reg      <= RING_F;
            push_rem_reg  <= 7'd0;
            front_reg     <= 7'd0;
            pop_mode_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            free_reg      <= free_next;
            push_rem_reg  <= push_rem_next;
            front_reg     <= front_next;
            pop_mode_reg  <= pop_mode_next;
            if (res_load)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

// File: rtl/length_prefixed_record_ring_fifo.sv
// order: a single-result transaction passes the command queue, the back-end sequencer and
// the output register; the first byte of a pop or peek also passes the registered memory read
// throughput: one single-result transaction per cycle, set by the back-end sequencer,
// while the output register is free; a pop or peek holds the sequencer while its bytes
// stream, and a pop that leaves records behind also reloads the next header
// reset: head, tail and queue pointers zero, ring empty, command queue and output
// register empty; the ring memory itself is not cleared
module length_prefixed_record_ring_fifo #(
    parameter int RING_BYTES = 256,
    parameter int MAX_RECORD = 64
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [2:0] req_type,
    input  logic [6:0] length,
    input  logic [7:0] data_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [1:0] status,
    output logic [7:0] out_byte,
    output logic       last,
    output logic [6:0] stored_len,
    output logic       is_empty,
    output logic [8:0] free_bytes,
    output logic       fits
);

    // front end decodes the request and parks it in a two-deep command queue,
    // so new transactions keep arriving while the back end streams a record
    logic           cmd_valid;
    logic           cmd_pop;
    lprf_pkg::cmd_t cmd;
    lprf_pkg::res_t res;

    lprf_front #(
        .MAX_RECORD (MAX_RECORD)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .req_type  (req_type),
        .length    (length),
        .data_byte (data_byte),
        .cmd_valid (cmd_valid),
        .cmd_pop   (cmd_pop),
        .cmd       (cmd)
    );

    // back end owns the ring memory, the pointers and the output register;
    // it keeps the front record's header in a register so every result can
    // report it without a memory read
    lprf_back #(
        .RING_BYTES (RING_BYTES),
        .MAX_RECORD (MAX_RECORD)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .res_valid (out_valid),
        .res_ready (out_ready),
        .res       (res)
    );

    assign status     = res.status;
    assign out_byte   = res.out_byte;
    assign last       = res.last;
    assign stored_len = res.stored_len;
    assign is_empty   = res.is_empty;
    assign free_bytes = res.free_bytes;
    assign fits       = res.fits;

`ifndef SYNTHESIS
    // an empty-queue answer is a single final transaction on an empty ring
    a_empty_status: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status == lprf_pkg::STATUS_EMPTY)) |-> (is_empty && last))
        else $error("empty status without empty ring or last");

    // an empty ring reports all bytes free
    a_empty_free: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && is_empty) |-> (free_bytes == 9'(RING_BYTES)))
        else $error("empty ring with wrong free count");

    // fits only on a check_space answer, which is a single ok transaction
    a_fits_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && fits) |-> ((status == lprf_pkg::STATUS_OK) && last))
        else $error("fits raised outside check_space answer");

    // record bytes stream without gaps once the consumer takes them
    a_stream_gapless: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && (status == lprf_pkg::STATUS_DATA) && !last)
        |=> (out_valid && (status == lprf_pkg::STATUS_DATA)))
        else $error("gap inside record byte stream");
`endif

endmodule
